/* sv/pdmt_pkg.sv */
// Package for the PGN dispatch match table.
// Command and status codes, identifier layout constants and field widths.
// No dependencies.
`timescale 1ns / 1ps

package pdmt_pkg;

    localparam int IDENT_W  = 29;
    localparam int PGN_W    = 18;
    localparam int ADDR8_W  = 8;
    localparam int MASK_W   = 16;
    localparam int GIVEN_W  = 4;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [PGN_W-1:0]    pgn_t;

    localparam cmd_t CMD_FRAME = 2'd0;
    localparam cmd_t CMD_REG   = 2'd1;
    localparam cmd_t CMD_UNREG = 2'd2;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_FULL = 2'd1;
    localparam status_t STATUS_BAD  = 2'd2;
    localparam status_t STATUS_EDP  = 2'd3;

    localparam logic [7:0] PDU2_CUTOFF  = 8'hF0;
    localparam logic [7:0] BROADCAST_DA = 8'hFF;

    localparam int IDENT_EDP_POS = 25;
    localparam int IDENT_DP_POS  = 24;

endpackage

/* sv/pdmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pdmt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pgn_dispatch_match_table_top.sv */
// Top level of the PGN dispatch match table: command sequencer, slot scan and results.
// Depends on pdmt_pkg and pdmt_ram.
//
//   channel   direction  handshake                 payload
//   command   in         start / busy              cmd, can_ident, reg_pgn, slot_index
//   config    in         cfg_valid / cfg_ready     cfg_data (fallback_enable)
//   result    out        result_valid (strobe)     status, slot_given, match_mask, handled,
//                                                  to_fallback, frame_pgn, dest_addr, src_addr
//
// One slot per cycle goes through the shared PGN comparator, reading the slot RAM.
// Frame: after accept, EXEC, then a SCAN of every slot, then LAST, then the result registers.
// Register: the scan stops at the first free slot, or reports full at the last used slot.
// Unregister, EDP frame and unknown command finish in EXEC. Busy holds until the strobe.
// Reset clears all slots at once; no pass over the RAM. The result strobe lasts one cycle
// and the receiver cannot stall it.
`timescale 1ns / 1ps

module pgn_dispatch_match_table_top
    import pdmt_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [IDENT_W-1:0]   can_ident,
    input  logic [PGN_W-1:0]     reg_pgn,
    input  logic [ADDR8_W-1:0]   slot_index,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output logic                 result_valid,
    output logic [STATUS_W-1:0]  status,
    output logic [GIVEN_W-1:0]   slot_given,
    output logic [MASK_W-1:0]    match_mask,
    output logic                 handled,
    output logic                 to_fallback,
    output logic [PGN_W-1:0]     frame_pgn,
    output logic [ADDR8_W-1:0]   dest_addr,
    output logic [ADDR8_W-1:0]   src_addr
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [ADDR8_W:0] SLOTS_LIM = (ADDR8_W + 1)'(TABLE_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_LAST = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]          cmp_idx_reg;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic                   fallback_reg;
    logic                   result_valid_reg, result_valid_next;

    cmd_t                   cmd_reg, cmd_next;
    logic [IDENT_W-1:0]     ident_reg, ident_next;
    pgn_t                   rpgn_reg, rpgn_next;
    logic [ADDR8_W-1:0]     sidx_reg, sidx_next;
    logic [MASK_W-1:0]      mask_acc_reg, mask_acc_next;
    logic                   hit_acc_reg, hit_acc_next;

    status_t                status_reg, status_next;
    logic [GIVEN_W-1:0]     given_reg, given_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic                   handled_reg, handled_next;
    logic                   fb_reg, fb_next;
    pgn_t                   fpgn_reg, fpgn_next;
    logic [ADDR8_W-1:0]     da_reg, da_next;
    logic [ADDR8_W-1:0]     sa_reg, sa_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    pgn_t                   ram_rdata;

    logic [7:0]             dec_pf;
    logic [7:0]             dec_ps;
    logic                   dec_pdu1;
    pgn_t                   dec_pgn;
    logic [ADDR8_W-1:0]     dec_da;
    logic                   hit;
    logic [MASK_W-1:0]      hit_mask;
    logic [MASK_W-1:0]      mask_fin;
    logic                   hit_fin;

    pdmt_ram #(
        .WIDTH (PGN_W),
        .DEPTH (TABLE_SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rpgn_reg),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign dec_pf   = ident_reg[23:16];
    assign dec_ps   = ident_reg[15:8];
    assign dec_pdu1 = dec_pf < PDU2_CUTOFF;
    assign dec_pgn  = {ident_reg[IDENT_EDP_POS], ident_reg[IDENT_DP_POS], dec_pf,
                       dec_pdu1 ? 8'h00 : dec_ps};
    assign dec_da   = dec_pdu1 ? dec_ps : BROADCAST_DA;

    assign hit      = cmp_vld_reg && used_reg[cmp_idx_reg] && (ram_rdata == dec_pgn);
    assign hit_mask = MASK_W'(hit) << cmp_idx_reg;
    assign mask_fin = mask_acc_reg | hit_mask;
    assign hit_fin  = hit_acc_reg | hit;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cmp_vld_next      = 1'b0;
        used_next         = used_reg;
        result_valid_next = 1'b0;
        cmd_next          = cmd_reg;
        ident_next        = ident_reg;
        rpgn_next         = rpgn_reg;
        sidx_next         = sidx_reg;
        mask_acc_next     = mask_fin;
        hit_acc_next      = hit_fin;
        status_next       = status_reg;
        given_next        = given_reg;
        mask_next         = mask_reg;
        handled_next      = handled_reg;
        fb_next           = fb_reg;
        fpgn_next         = fpgn_reg;
        da_next           = da_reg;
        sa_next           = sa_reg;
        ram_we            = 1'b0;
        ram_waddr         = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    ident_next    = can_ident;
                    rpgn_next     = reg_pgn;
                    sidx_next     = slot_index;
                    cnt_next      = '0;
                    mask_acc_next = '0;
                    hit_acc_next  = 1'b0;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next  = STATUS_OK;
                given_next   = '0;
                mask_next    = '0;
                handled_next = 1'b0;
                fb_next      = 1'b0;
                fpgn_next    = '0;
                da_next      = '0;
                sa_next      = '0;
                case (cmd_reg)
                    CMD_FRAME:
                    begin
                        if (ident_reg[IDENT_EDP_POS])
                        begin
                            status_next       = STATUS_EDP;
                            fpgn_next         = dec_pgn;
                            da_next           = dec_da;
                            sa_next           = ident_reg[7:0];
                            result_valid_next = 1'b1;
                            state_next        = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_REG:
                    begin
                        state_next = ST_SCAN;
                    end
                    CMD_UNREG:
                    begin
                        if (({1'b0, sidx_reg} < SLOTS_LIM) && used_reg[sidx_reg[IW-1:0]])
                        begin
                            used_next[sidx_reg[IW-1:0]] = 1'b0;
                        end
                        else
                        begin
                            status_next = STATUS_BAD;
                        end
                        result_valid_next = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    default:
                    begin
                        result_valid_next = 1'b1;
                        state_next        = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (cmd_reg == CMD_REG)
                begin
                    if (!used_reg[cnt_reg])
                    begin
                        ram_we             = 1'b1;
                        used_next[cnt_reg] = 1'b1;
                        status_next        = STATUS_OK;
                        given_next         = GIVEN_W'(cnt_reg);
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else if (cnt_reg == LAST_IDX)
                    begin
                        status_next       = STATUS_FULL;
                        result_valid_next = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_LAST:
            begin
                status_next       = STATUS_OK;
                mask_next         = mask_fin;
                handled_next      = hit_fin;
                fb_next           = !hit_fin && fallback_reg;
                fpgn_next         = dec_pgn;
                da_next           = dec_da;
                sa_next           = ident_reg[7:0];
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            cmp_vld_reg      <= 1'b0;
            used_reg         <= '0;
            fallback_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            used_reg         <= used_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                fallback_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cnt_reg;
        cmd_reg      <= cmd_next;
        ident_reg    <= ident_next;
        rpgn_reg     <= rpgn_next;
        sidx_reg     <= sidx_next;
        mask_acc_reg <= mask_acc_next;
        hit_acc_reg  <= hit_acc_next;
        status_reg   <= status_next;
        given_reg    <= given_next;
        mask_reg     <= mask_next;
        handled_reg  <= handled_next;
        fb_reg       <= fb_next;
        fpgn_reg     <= fpgn_next;
        da_reg       <= da_next;
        sa_reg       <= sa_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign slot_given   = given_reg;
    assign match_mask   = mask_reg;
    assign handled      = handled_reg;
    assign to_fallback  = fb_reg;
    assign frame_pgn    = fpgn_reg;
    assign dest_addr    = da_reg;
    assign src_addr     = sa_reg;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(handled && to_fallback))
        else $error("frame both handled and sent to fallback");

    a_edp_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_EDP) |-> (match_mask == '0 && !handled))
        else $error("EDP frame reported a match");

endmodule

/* verif/pgn_dispatch_match_table_top_tb.sv */
// Testbench for pgn_dispatch_match_table_top: directed and random command traffic.
// Each result is checked against a slot-table predictor kept in the bench.
// Depends on pdmt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module pgn_dispatch_match_table_top_tb;
    import pdmt_pkg::*;

    localparam int   SLOTS     = 16;
    localparam int   POOL_SIZE = 8;
    localparam cmd_t CMD_NONE  = 2'd3;
    localparam pgn_t PGN_PDU1  = 18'h0EF00;
    localparam pgn_t PGN_PDU2  = 18'h0F0CA;

    typedef struct packed {
        cmd_t                op;
        logic [IDENT_W-1:0]  ident;
        pgn_t                pgn;
        logic [ADDR8_W-1:0]  slot;
    } dispatch_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [GIVEN_W-1:0]  given;
        logic [MASK_W-1:0]   mask;
        logic                handled;
        logic                fallback;
        pgn_t                pgn;
        logic [ADDR8_W-1:0]  dest;
        logic [ADDR8_W-1:0]  src;
    } dispatch_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     cmd = '0;
    logic [IDENT_W-1:0]   can_ident = '0;
    logic [PGN_W-1:0]     reg_pgn = '0;
    logic [ADDR8_W-1:0]   slot_index = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;
    logic                 result_valid;
    logic [STATUS_W-1:0]  status;
    logic [GIVEN_W-1:0]   slot_given;
    logic [MASK_W-1:0]    match_mask;
    logic                 handled;
    logic                 to_fallback;
    logic [PGN_W-1:0]     frame_pgn;
    logic [ADDR8_W-1:0]   dest_addr;
    logic [ADDR8_W-1:0]   src_addr;

    logic             tbl_used [SLOTS];
    pgn_t             tbl_pgn [SLOTS];
    logic             fallback_on;
    pgn_t             pgn_pool [POOL_SIZE];
    dispatch_result_t predicted_results [$];

    int error_count;
    int n_frame, n_matched, n_fallback, n_edp;
    int n_reg, n_full, n_unreg, n_bad, n_unknown;

    pgn_dispatch_match_table_top #(
        .TABLE_SLOTS (SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .can_ident    (can_ident),
        .reg_pgn      (reg_pgn),
        .slot_index   (slot_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .slot_given   (slot_given),
        .match_mask   (match_mask),
        .handled      (handled),
        .to_fallback  (to_fallback),
        .frame_pgn    (frame_pgn),
        .dest_addr    (dest_addr),
        .src_addr     (src_addr)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic dispatch_result_t predict_dispatch(dispatch_cmd_t it);
        dispatch_result_t res;
        logic [7:0]       pf;
        logic [7:0]       ps;
        logic             found;
        res = '0;
        found = 1'b0;
        case (it.op)
            CMD_FRAME:
            begin
                pf = it.ident[23:16];
                ps = it.ident[15:8];
                res.src = it.ident[7:0];
                if (pf < PDU2_CUTOFF)
                begin
                    res.dest = ps;
                    ps = '0;
                end
                else
                begin
                    res.dest = BROADCAST_DA;
                end
                res.pgn = {it.ident[IDENT_EDP_POS], it.ident[IDENT_DP_POS], pf, ps};
                if (it.ident[IDENT_EDP_POS])
                begin
                    res.status = STATUS_EDP;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_used[i] && tbl_pgn[i] == res.pgn)
                            res.mask[i] = 1'b1;
                    res.handled = |res.mask;
                    res.fallback = !res.handled && fallback_on;
                end
            end
            CMD_REG:
            begin
                res.status = STATUS_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !tbl_used[i])
                    begin
                        found = 1'b1;
                        tbl_used[i] = 1'b1;
                        tbl_pgn[i] = it.pgn;
                        res.given = i[GIVEN_W-1:0];
                        res.status = STATUS_OK;
                    end
                end
            end
            CMD_UNREG:
            begin
                if (it.slot < SLOTS && tbl_used[it.slot])
                begin
                    tbl_used[it.slot] = 1'b0;
                    tbl_pgn[it.slot] = '0;
                end
                else
                begin
                    res.status = STATUS_BAD;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic dispatch_cmd_t random_fields();
        dispatch_cmd_t it;
        it.op    = cmd_t'($urandom_range(3));
        it.ident = IDENT_W'($urandom);
        it.pgn   = pgn_t'($urandom);
        it.slot  = ADDR8_W'($urandom_range(255));
        return it;
    endfunction

    // PDU1 PGNs get a random destination in PS; it drops out of the decoded PGN.
    function automatic logic [IDENT_W-1:0] ident_for_pgn(pgn_t p);
        logic [7:0] ps;
        ps = (p[15:8] < PDU2_CUTOFF) ? 8'($urandom_range(255)) : p[7:0];
        return {3'($urandom_range(7)), p[17:16], p[15:8], ps, 8'($urandom_range(255))};
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic send_command(input dispatch_cmd_t it);
        dispatch_result_t want;
        start      <= 1'b1;
        cmd        <= it.op;
        can_ident  <= it.ident;
        reg_pgn    <= it.pgn;
        slot_index <= it.slot;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = predict_dispatch(it);
        predicted_results.push_back(want);
        case (it.op)
            CMD_FRAME:
            begin
                n_frame++;
                n_matched  += int'(want.handled);
                n_fallback += int'(want.fallback);
                n_edp      += int'(want.status == STATUS_EDP);
            end
            CMD_REG:
            begin
                n_reg++;
                n_full += int'(want.status == STATUS_FULL);
            end
            CMD_UNREG:
            begin
                n_unreg++;
                n_bad += int'(want.status == STATUS_BAD);
            end
            default:
                n_unknown++;
        endcase
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_table_idle();
        start <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_fallback(input logic enable);
        wait_table_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        fallback_on = enable;
    endtask

    always @(posedge clk)
    begin
        dispatch_result_t want;
        if (result_valid === 1'b1)
        begin
            if (predicted_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(status), 0);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (slot_given !== want.given)
                    report_mismatch("slot_given", 32'(slot_given), 32'(want.given));
                if (match_mask !== want.mask)
                    report_mismatch("match_mask", 32'(match_mask), 32'(want.mask));
                if (handled !== want.handled)
                    report_mismatch("handled", 32'(handled), 32'(want.handled));
                if (to_fallback !== want.fallback)
                    report_mismatch("to_fallback", 32'(to_fallback), 32'(want.fallback));
                if (frame_pgn !== want.pgn)
                    report_mismatch("frame_pgn", 32'(frame_pgn), 32'(want.pgn));
                if (dest_addr !== want.dest)
                    report_mismatch("dest_addr", 32'(dest_addr), 32'(want.dest));
                if (src_addr !== want.src)
                    report_mismatch("src_addr", 32'(src_addr), 32'(want.src));
            end
        end
    end

    task automatic test_frame_decode();
        dispatch_cmd_t it;
        it = random_fields();
        it.op = CMD_FRAME;
        it.ident = '0;
        send_command(it);
        write_fallback(1'b1);
        it = random_fields();
        it.op = CMD_FRAME;
        it.ident = '0;
        send_command(it);
        it = random_fields();
        it.op = CMD_FRAME;
        it.ident = '1;
        send_command(it);
        it = random_fields();
        it.op = CMD_NONE;
        send_command(it);
    endtask

    task automatic test_table_fill();
        dispatch_cmd_t it;
        for (int i = 0; i < SLOTS; i++)
        begin
            it = random_fields();
            it.op = CMD_REG;
            if (i == 0)
                it.pgn = '1;
            else if (i == 1)
                it.pgn = '0;
            else
                it.pgn = i[0] ? PGN_PDU2 : PGN_PDU1;
            send_command(it);
        end
        it = random_fields();
        it.op = CMD_REG;
        send_command(it);
        it = random_fields();
        it.op = CMD_FRAME;
        it.ident = ident_for_pgn(PGN_PDU1);
        send_command(it);
        it = random_fields();
        it.op = CMD_FRAME;
        it.ident = ident_for_pgn(PGN_PDU2);
        send_command(it);
    endtask

    task automatic test_unregister();
        dispatch_cmd_t it;
        it = random_fields();
        it.op = CMD_UNREG;
        it.slot = '0;
        send_command(it);
        send_command(it);
        it.slot = ADDR8_W'(SLOTS);
        send_command(it);
        it.slot = '1;
        send_command(it);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int count);
        dispatch_cmd_t it;
        int            roll;
        logic [7:0]    pf;
        logic [7:0]    low;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pf  = 8'($urandom_range(255));
            low = (pf < PDU2_CUTOFF && $urandom_range(7) != 0) ? 8'h00 : 8'($urandom_range(255));
            pgn_pool[i] = {($urandom_range(15) == 0), 1'($urandom_range(1)), pf, low};
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < idle_pct)
                idle_sender($urandom_range(1, ($urandom_range(3) == 0) ? 24 : 4));
            it = random_fields();
            roll = $urandom_range(99);
            if (roll < 50)
            begin
                it.op = CMD_FRAME;
                roll = $urandom_range(9);
                if (roll < 7)
                    it.ident = ident_for_pgn(pgn_pool[$urandom_range(POOL_SIZE-1)]);
                else if (roll == 7)
                    it.ident[IDENT_EDP_POS] = 1'b1;
            end
            else if (roll < 74)
            begin
                it.op = CMD_REG;
                if ($urandom_range(4) != 0)
                    it.pgn = pgn_pool[$urandom_range(POOL_SIZE-1)];
            end
            else if (roll < 94)
            begin
                it.op = CMD_UNREG;
                if ($urandom_range(6) != 0)
                    it.slot = ADDR8_W'($urandom_range(SLOTS-1));
            end
            else
            begin
                it.op = CMD_NONE;
            end
            send_command(it);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_pgn[i]  = '0;
        end
        fallback_on = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_frame_decode();
        test_table_fill();
        test_unregister();
        write_fallback(1'b1);
        test_random_traffic(15, 240);
        write_fallback(1'b0);
        test_random_traffic(70, 230);
        write_fallback(1'b1);
        test_random_traffic(0, 230);

        wait_table_idle();
        repeat (25) @(posedge clk);
        $display("covered %0d frames (%0d matched, %0d to fallback, %0d EDP refused)",
                 n_frame, n_matched, n_fallback, n_edp);
        $display("and %0d registers (%0d full), %0d unregisters (%0d bad), %0d unknown commands",
                 n_reg, n_full, n_unreg, n_bad, n_unknown);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results still pending", $realtime, predicted_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/pdmt_pkg.sv
sv/pdmt_ram.sv
sv/pgn_dispatch_match_table_top.sv
verif/pgn_dispatch_match_table_top_tb.sv
